FILE: hw/rtl/fqt_pkg.sv
`timescale 1ns / 1ps
// shared types, codes and sizes for the free quarantine table
package fqt_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int PTR_W    = $clog2(CAPACITY + 1);

    localparam logic [1:0] ACT_ADD   = 2'd0;
    localparam logic [1:0] ACT_DEACT = 2'd1;
    localparam logic [1:0] ACT_READ  = 2'd2;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_BAD_INDEX  = 2'd1;
    localparam logic [1:0] ST_NOT_ACTIVE = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_FETCH,
        S_EVICT,
        S_RDWAIT
    } t_state;

    typedef struct packed {
        logic [15:0] start_page;
        logic [15:0] page_count;
        logic [31:0] requested_size;
        logic [7:0]  zone;
        logic [31:0] sequence_no;
    } t_entry;

    typedef struct packed {
        logic clear;
        logic sample;
    } t_scan_ctl;

    typedef struct packed {
        logic [1:0]  status;
        logic        evicted;
        logic [7:0]  slot_used;
        logic [15:0] start_page;
        logic [15:0] page_count;
        logic [31:0] requested_size;
        logic [7:0]  zone;
        logic [31:0] sequence_no;
        logic        active;
        logic [8:0]  active_count;
        logic        is_empty;
        logic        is_full;
    } t_result;

endpackage

FILE: hw/rtl/free_quarantine_table_unit.sv
`timescale 1ns / 1ps
// top level of the free quarantine table: command sequencer, flags and result register
//
// an item is taken at a rising edge with start high and busy low; action selects
// add, deactivate or read. each item gives one result beat, shown for exactly one
// cycle with o_strobe high; the receiver cannot stall and must take it then.
// for add to a table with a free slot, for deactivate, for a bad index and for
// the unused action code, the strobe shows in the cycle after the accept; a read
// of a good index first passes through S_RDWAIT, as it waits on the registered
// slot memory port. busy is low again when the strobe shows, so the next item
// may be taken then: one item per cycle for the cases without S_RDWAIT, while a read holds busy until its strobe.
// an add to a full table sweeps every slot through the one memory read port and
// the shared stamp comparator, one slot per cycle, then fetches the oldest entry.
// busy is high for the whole sweep.
// reset (synchronous, active low) marks all slots inactive and unwritten, sets
// the count to zero and the stamp to one; no clearing pass is needed, a slot
// never written reads as zero.
module free_quarantine_table_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_action,
    input  logic [15:0] i_start_page,
    input  logic [15:0] i_page_count,
    input  logic [31:0] i_requested_size,
    input  logic [7:0]  i_zone_index,
    input  logic [7:0]  i_index,
    output logic        o_strobe,
    output logic [1:0]  o_status,
    output logic        o_evicted,
    output logic [7:0]  o_slot_used,
    output logic [15:0] o_out_start_page,
    output logic [15:0] o_out_page_count,
    output logic [31:0] o_out_requested_size,
    output logic [7:0]  o_out_zone_index,
    output logic [31:0] o_out_sequence,
    output logic        o_out_active,
    output logic [8:0]  o_active_count,
    output logic        o_is_empty,
    output logic        o_is_full
);

    localparam int CAP   = fqt_pkg::CAPACITY;
    localparam int IDX_W = fqt_pkg::IDX_W;
    localparam int PTR_W = fqt_pkg::PTR_W;

    fqt_pkg::t_state  r_state, n_state;
    logic [PTR_W-1:0] r_ptr, n_ptr;
    logic [CAP-1:0]   r_valid, n_valid;
    logic [CAP-1:0]   r_written, n_written;
    logic [8:0]       r_live, n_live;
    logic [31:0]      r_stamp, n_stamp;
    logic [IDX_W-1:0] r_idx, n_idx;
    fqt_pkg::t_entry  r_new, n_new;
    fqt_pkg::t_result r_res, n_res;
    logic             r_strobe, n_strobe;

    logic               mem_we;
    logic [IDX_W-1:0]   mem_waddr;
    fqt_pkg::t_entry    mem_wdata;
    logic [IDX_W-1:0]   mem_raddr;
    fqt_pkg::t_entry    mem_rdata;
    fqt_pkg::t_scan_ctl scan_ctl;
    logic [IDX_W-1:0]   scan_idx;
    logic [IDX_W-1:0]   best_idx;
    logic [IDX_W-1:0]   free_slot;
    logic [IDX_W-1:0]   in_idx;
    logic               idx_bad;
    logic               full;

    fqt_entry_mem u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    fqt_oldest_scan u_scan (
        .i_clk      (i_clk),
        .i_ctl      (scan_ctl),
        .i_valid    (r_valid[scan_idx]),
        .i_seq      (mem_rdata.sequence_no),
        .i_idx      (scan_idx),
        .o_best_idx (best_idx)
    );

    // lowest inactive slot
    always_comb begin
        free_slot = '0;
        for (int i = CAP - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                free_slot = IDX_W'(i);
            end
        end
    end

    assign in_idx   = i_index[IDX_W-1:0];
    assign idx_bad  = {1'b0, i_index} >= 9'(CAP);
    assign full     = r_live >= 9'(CAP);
    assign scan_idx = IDX_W'(r_ptr - PTR_W'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= fqt_pkg::S_IDLE;
            r_ptr     <= '0;
            r_valid   <= '0;
            r_written <= '0;
            r_live    <= '0;
            r_stamp   <= 32'd1;
            r_strobe  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_ptr     <= n_ptr;
            r_valid   <= n_valid;
            r_written <= n_written;
            r_live    <= n_live;
            r_stamp   <= n_stamp;
            r_strobe  <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        r_new <= n_new;
        r_res <= n_res;
    end

    always_comb begin
        n_state   = r_state;
        n_ptr     = r_ptr;
        n_valid   = r_valid;
        n_written = r_written;
        n_live    = r_live;
        n_stamp   = r_stamp;
        n_idx     = r_idx;
        n_new     = r_new;
        n_res     = r_res;
        n_strobe  = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = free_slot;
        mem_wdata = '{start_page: i_start_page, page_count: i_page_count,
                      requested_size: i_requested_size, zone: i_zone_index,
                      sequence_no: r_stamp};
        mem_raddr = r_ptr[IDX_W-1:0];
        scan_ctl  = '0;

        case (r_state)
            fqt_pkg::S_IDLE: begin
                if (start) begin
                    n_res = '0;
                    case (i_action)
                        fqt_pkg::ACT_ADD: begin
                            if (full) begin
                                n_new          = mem_wdata;
                                n_ptr          = '0;
                                scan_ctl.clear = 1'b1;
                                n_state        = fqt_pkg::S_SCAN;
                            end else begin
                                mem_we               = 1'b1;
                                n_valid[free_slot]   = 1'b1;
                                n_written[free_slot] = 1'b1;
                                n_live               = r_live + 9'd1;
                                n_stamp              = r_stamp + 32'd1;
                                n_res.slot_used      = 8'(free_slot);
                                n_strobe             = 1'b1;
                            end
                        end
                        fqt_pkg::ACT_DEACT: begin
                            n_res.slot_used = i_index;
                            n_strobe        = 1'b1;
                            if (idx_bad) begin
                                n_res.status = fqt_pkg::ST_BAD_INDEX;
                            end else if (!r_valid[in_idx]) begin
                                n_res.status = fqt_pkg::ST_NOT_ACTIVE;
                            end else begin
                                n_valid[in_idx] = 1'b0;
                                n_live          = r_live - 9'd1;
                            end
                        end
                        fqt_pkg::ACT_READ: begin
                            n_res.slot_used = i_index;
                            if (idx_bad) begin
                                n_res.status = fqt_pkg::ST_BAD_INDEX;
                                n_strobe     = 1'b1;
                            end else begin
                                mem_raddr = in_idx;
                                n_idx     = in_idx;
                                n_state   = fqt_pkg::S_RDWAIT;
                            end
                        end
                        default: begin
                            n_strobe = 1'b1;
                        end
                    endcase
                end
            end
            fqt_pkg::S_SCAN: begin
                scan_ctl.sample = r_ptr != '0;
                if (r_ptr == PTR_W'(CAP)) begin
                    n_state = fqt_pkg::S_FETCH;
                end else begin
                    n_ptr = r_ptr + PTR_W'(1);
                end
            end
            fqt_pkg::S_FETCH: begin
                mem_raddr = best_idx;
                n_state   = fqt_pkg::S_EVICT;
            end
            fqt_pkg::S_EVICT: begin
                n_res.evicted        = 1'b1;
                n_res.slot_used      = 8'(best_idx);
                n_res.start_page     = mem_rdata.start_page;
                n_res.page_count     = mem_rdata.page_count;
                n_res.requested_size = mem_rdata.requested_size;
                n_res.zone           = mem_rdata.zone;
                n_res.sequence_no    = mem_rdata.sequence_no;
                n_res.active         = 1'b0;
                mem_we               = 1'b1;
                mem_waddr            = best_idx;
                mem_wdata            = r_new;
                mem_wdata.sequence_no = r_stamp;
                n_valid[best_idx]    = 1'b1;
                n_written[best_idx]  = 1'b1;
                n_stamp              = r_stamp + 32'd1;
                n_strobe             = 1'b1;
                n_state              = fqt_pkg::S_IDLE;
            end
            fqt_pkg::S_RDWAIT: begin
                if (r_written[r_idx]) begin
                    n_res.start_page     = mem_rdata.start_page;
                    n_res.page_count     = mem_rdata.page_count;
                    n_res.requested_size = mem_rdata.requested_size;
                    n_res.zone           = mem_rdata.zone;
                    n_res.sequence_no    = mem_rdata.sequence_no;
                end
                n_res.active = r_valid[r_idx];
                n_strobe     = 1'b1;
                n_state      = fqt_pkg::S_IDLE;
            end
            default: begin
                n_state = fqt_pkg::S_IDLE;
            end
        endcase

        n_res.active_count = n_live;
        n_res.is_empty     = n_live == 9'd0;
        n_res.is_full      = n_live >= 9'(CAP);
    end

    assign busy                 = r_state != fqt_pkg::S_IDLE;
    assign o_strobe             = r_strobe;
    assign o_status             = r_res.status;
    assign o_evicted            = r_res.evicted;
    assign o_slot_used          = r_res.slot_used;
    assign o_out_start_page     = r_res.start_page;
    assign o_out_page_count     = r_res.page_count;
    assign o_out_requested_size = r_res.requested_size;
    assign o_out_zone_index     = r_res.zone;
    assign o_out_sequence       = r_res.sequence_no;
    assign o_out_active         = r_res.active;
    assign o_active_count       = r_res.active_count;
    assign o_is_empty           = r_res.is_empty;
    assign o_is_full            = r_res.is_full;

endmodule

FILE: hw/rtl/fqt_entry_mem.sv
`timescale 1ns / 1ps
// slot storage: one write port, one registered read port
module fqt_entry_mem (
    input  logic                      i_clk,
    input  logic                      i_we,
    input  logic [fqt_pkg::IDX_W-1:0] i_waddr,
    input  fqt_pkg::t_entry           i_wdata,
    input  logic [fqt_pkg::IDX_W-1:0] i_raddr,
    output fqt_pkg::t_entry           o_rdata
);

    fqt_pkg::t_entry r_mem [fqt_pkg::CAPACITY];
    fqt_pkg::t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hw/rtl/fqt_oldest_scan.sv
`timescale 1ns / 1ps
// running minimum of stamps over a slot sweep, ties to the lowest slot
module fqt_oldest_scan (
    input  logic                      i_clk,
    input  fqt_pkg::t_scan_ctl        i_ctl,
    input  logic                      i_valid,
    input  logic [31:0]               i_seq,
    input  logic [fqt_pkg::IDX_W-1:0] i_idx,
    output logic [fqt_pkg::IDX_W-1:0] o_best_idx
);

    logic                      r_found;
    logic [31:0]               r_best_seq;
    logic [fqt_pkg::IDX_W-1:0] r_best_idx;
    logic                      take;

    assign take = i_ctl.sample && i_valid && (!r_found || (i_seq < r_best_seq));

    always_ff @(posedge i_clk) begin
        if (i_ctl.clear) begin
            r_found <= 1'b0;
        end else if (take) begin
            r_found    <= 1'b1;
            r_best_seq <= i_seq;
            r_best_idx <= i_idx;
        end
    end

    assign o_best_idx = r_best_idx;

endmodule
